@@ src/mrrm_pkg.sv @@
// Package for the monotone run range maximum block.
// Shared constants, selector and direction codes, controller/datapath structs.
// No dependencies.
package mrrm_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int VALUE_BITS_DEF  = 16;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    DIR_FLAT = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic load_start;
    logic load_append;
    logic q_start;
    logic out_bad;
    logic rd_first;
    logic rd_last;
    logic run0;
    logic runrd;
    logic cand;
    logic out_final;
  } ctl_cmd_t;

  typedef struct packed {
    logic q_bad;
    logic run_last;
  } dp_stat_t;

endpackage

@@ src/monotone_run_range_max.sv @@
// Loads are accepted back to back.
// A valid query walks S_RFIRST, S_RLAST, S_RUN0, then S_CAND/S_RUNRD per run, then S_FINAL; a bad
// query has its result the next cycle. Each run costs a run-table read then a sample read.
// One query is worked on at a time; loads wait while a query walks.
// Reset (rst, synchronous) empties the sample set; store contents are not cleared.
// Top level: instantiates mrrm_ctrl and mrrm_dp; depends on mrrm_pkg.
module monotone_run_range_max #(
  parameter int MAX_SAMPLES = mrrm_pkg::MAX_SAMPLES_DEF,
  parameter int VALUE_BITS  = mrrm_pkg::VALUE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_SAMPLES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic signed [VALUE_BITS-1:0] sample_value,
  input  logic [IDX_W-1:0]             start_index,
  input  logic [IDX_W-1:0]             end_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] max_value,
  output logic                         status
);

  mrrm_pkg::ctl_cmd_t cmd;
  mrrm_pkg::dp_stat_t stat;

  mrrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrrm_dp #(.MAX_SAMPLES(MAX_SAMPLES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_value (sample_value),
    .start_index  (start_index),
    .end_index    (end_index),
    .max_value    (max_value),
    .status       (status)
  );

endmodule

@@ src/mrrm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mrrm_ctrl.sv @@
// Controller for the monotone run range maximum block: handshakes and query sequencing.
// Depends on mrrm_pkg.
module mrrm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  output logic                out_valid,
  input  logic                out_stall,
  input  mrrm_pkg::dp_stat_t  stat,
  output mrrm_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RFIRST = 7'b0000010,
    S_RLAST  = 7'b0000100,
    S_RUN0   = 7'b0001000,
    S_CAND   = 7'b0010000,
    S_RUNRD  = 7'b0100000,
    S_FINAL  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (out_valid && func == mrrm_pkg::FUNC_QUERY);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load_start  = accept && func == mrrm_pkg::FUNC_START;
        cmd.load_append = accept && func == mrrm_pkg::FUNC_APPEND;
        cmd.q_start     = accept && func == mrrm_pkg::FUNC_QUERY;
        cmd.out_bad     = cmd.q_start && stat.q_bad;
        if (cmd.q_start && !stat.q_bad) begin
          state_next = S_RFIRST;
        end
      end
      S_RFIRST: begin
        cmd.rd_first = 1'b1;
        state_next   = S_RLAST;
      end
      S_RLAST: begin
        cmd.rd_last = 1'b1;
        state_next  = S_RUN0;
      end
      S_RUN0: begin
        cmd.run0   = 1'b1;
        state_next = S_CAND;
      end
      S_CAND: begin
        cmd.cand   = 1'b1;
        state_next = stat.run_last ? S_FINAL : S_RUNRD;
      end
      S_RUNRD: begin
        cmd.runrd  = 1'b1;
        state_next = S_CAND;
      end
      S_FINAL: begin
        cmd.out_final = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_bad || cmd.out_final) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ src/mrrm_dp.sv @@
// Datapath for the monotone run range maximum block: run tracking, sample and
// run stores, query walk and result register. Depends on mrrm_pkg and mrrm_ram.
module mrrm_dp #(
  parameter int MAX_SAMPLES = mrrm_pkg::MAX_SAMPLES_DEF,
  parameter int VALUE_BITS  = mrrm_pkg::VALUE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_SAMPLES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mrrm_pkg::ctl_cmd_t           cmd,
  output mrrm_pkg::dp_stat_t           stat,
  input  logic signed [VALUE_BITS-1:0] sample_value,
  input  logic [IDX_W-1:0]             start_index,
  input  logic [IDX_W-1:0]             end_index,
  output logic signed [VALUE_BITS-1:0] max_value,
  output logic                         status
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SS_W  = VALUE_BITS + IDX_W;
  localparam int RT_W  = 1 + IDX_W;
  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [CNT_W-1:0]             sample_count;
  logic [IDX_W-1:0]             run_count;
  mrrm_pkg::dir_t               cur_dir;
  logic signed [VALUE_BITS-1:0] prev_sample;
  logic [IDX_W-1:0]             q_first, q_last, pos, r, r_last;
  logic signed [VALUE_BITS-1:0] best;

  mrrm_pkg::dir_t               new_dir;
  logic                         empty, full, start_eff, app_eff, dir_change, run_close;
  logic [CNT_W-1:0]             cnt_m1;
  logic [IDX_W-1:0]             last_idx, run_count_inc;

  logic                         ss_we, ss_re;
  logic [IDX_W-1:0]             ss_waddr, ss_raddr;
  logic [SS_W-1:0]              ss_wdata, ss_rdata;
  logic                         rt_we;
  logic [RT_W-1:0]              rt_wdata, rt_rdata;

  logic signed [VALUE_BITS-1:0] rd_value, best_cand;
  logic [IDX_W-1:0]             rd_run;
  logic                         in_closed, run_up;
  logic [IDX_W-1:0]             run_end, up_addr, cand_addr;

  // load path
  always_comb begin
    if (sample_value == prev_sample) begin
      new_dir = mrrm_pkg::DIR_FLAT;
    end else if (sample_value > prev_sample) begin
      new_dir = mrrm_pkg::DIR_UP;
    end else begin
      new_dir = mrrm_pkg::DIR_DOWN;
    end
  end

  assign empty         = sample_count == '0;
  assign full          = sample_count >= CNT_W'(MAX_SAMPLES);
  assign start_eff     = cmd.load_start || (cmd.load_append && empty);
  assign app_eff       = cmd.load_append && !empty && !full;
  assign dir_change    = new_dir != mrrm_pkg::DIR_FLAT && new_dir != cur_dir;
  assign run_close     = dir_change && cur_dir != mrrm_pkg::DIR_FLAT;
  assign cnt_m1        = sample_count - CNT_W'(1);
  assign last_idx      = cnt_m1[IDX_W-1:0];
  assign run_count_inc = run_count + IDX_W'(1);

  // query walk: current run's end and candidate address
  assign rd_value  = $signed(ss_rdata[VALUE_BITS-1:0]);
  assign rd_run    = ss_rdata[SS_W-1:VALUE_BITS];
  assign in_closed = r < run_count;
  assign run_end   = in_closed ? rt_rdata[IDX_W-1:0] : last_idx;
  assign run_up    = in_closed ? !rt_rdata[IDX_W] : (cur_dir == mrrm_pkg::DIR_UP);
  assign up_addr   = (run_end < q_last) ? run_end : q_last;
  assign cand_addr = run_up ? up_addr : pos;
  assign best_cand = (rd_value > best) ? rd_value : best;

  assign ss_we    = start_eff || app_eff;
  assign ss_waddr = start_eff ? '0 : sample_count[IDX_W-1:0];
  assign ss_wdata = start_eff ? {IDX_W'(0), sample_value}
                              : {(run_close ? run_count_inc : run_count), sample_value};
  assign ss_re    = cmd.rd_first || cmd.rd_last || cmd.cand;
  assign ss_raddr = cmd.rd_first ? q_first : (cmd.rd_last ? q_last : cand_addr);

  assign rt_we    = app_eff && run_close;
  assign rt_wdata = {cur_dir == mrrm_pkg::DIR_DOWN, last_idx};

  assign stat.q_bad    = (start_index > end_index) || (CNT_W'(end_index) >= sample_count);
  assign stat.run_last = r == r_last;

  mrrm_ram #(.WIDTH(SS_W), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (ss_we),
    .waddr (ss_waddr),
    .wdata (ss_wdata),
    .re    (ss_re),
    .raddr (ss_raddr),
    .rdata (ss_rdata)
  );

  mrrm_ram #(.WIDTH(RT_W), .DEPTH(MAX_SAMPLES)) u_run_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (run_count),
    .wdata (rt_wdata),
    .re    (cmd.run0 || cmd.runrd),
    .raddr (r),
    .rdata (rt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      run_count    <= '0;
      cur_dir      <= mrrm_pkg::DIR_FLAT;
      prev_sample  <= '0;
    end else if (start_eff) begin
      sample_count <= CNT_W'(1);
      run_count    <= '0;
      cur_dir      <= mrrm_pkg::DIR_FLAT;
      prev_sample  <= sample_value;
    end else if (app_eff) begin
      sample_count <= sample_count + CNT_W'(1);
      prev_sample  <= sample_value;
      if (run_close) begin
        run_count <= run_count_inc;
      end
      if (dir_change) begin
        cur_dir <= new_dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      q_first <= start_index;
      q_last  <= end_index;
      pos     <= start_index;
      best    <= MOST_NEG;
    end
    if (cmd.rd_last) begin
      r <= rd_run;
    end
    if (cmd.run0) begin
      r_last <= rd_run;
    end
    if (cmd.runrd) begin
      best <= best_cand;
    end
    if (cmd.cand) begin
      pos <= run_end + IDX_W'(1);
      r   <= r + IDX_W'(1);
    end
    if (cmd.out_bad) begin
      max_value <= MOST_NEG;
      status    <= 1'b1;
    end else if (cmd.out_final) begin
      max_value <= best_cand;
      status    <= 1'b0;
    end
  end

endmodule

@@ src/mrrm_checker.sv @@
// Port-level checks for monotone_run_range_max, bound to the top level.
// Depends on mrrm_pkg.
module mrrm_checker #(
  parameter int MAX_SAMPLES = mrrm_pkg::MAX_SAMPLES_DEF,
  parameter int VALUE_BITS  = mrrm_pkg::VALUE_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_SAMPLES)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   func,
  input logic [IDX_W-1:0]             start_index,
  input logic [IDX_W-1:0]             end_index,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [VALUE_BITS-1:0] max_value,
  input logic                         status
);

  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_bad_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> max_value == MOST_NEG)
    else $error("bad status word without most negative value");

  a_load_no_word: assert property (@(posedge clk) disable iff (rst)
    in_acc && func != mrrm_pkg::FUNC_QUERY |=> !$rose(out_valid))
    else $error("result word after a load");

  a_reversed_range: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == mrrm_pkg::FUNC_QUERY && start_index > end_index
      |=> out_valid && status)
    else $error("reversed range not flagged next cycle");

  a_no_query_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_acc && func == mrrm_pkg::FUNC_QUERY))
    else $error("query accepted while result word pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(status))
    else $error("stalled result word changed");

endmodule

bind monotone_run_range_max mrrm_checker #(
  .MAX_SAMPLES (MAX_SAMPLES),
  .VALUE_BITS  (VALUE_BITS)
) u_mrrm_checker (.*);
